/* rtl/tgr_pkg.sv */
package tgr_pkg;

  // Reciprocals carry 30 fraction bits; the widest one (size 6) fits in 28 bits.
  localparam int RECIP_BITS = 30;
  localparam int RECIP_W    = 28;
  localparam longint unsigned INV_H_NUM = 64'd1239850262;  // round(2/sqrt(3) * 2^30)

  localparam int SIZE_W     = 6;
  localparam int SIZE_MIN   = 6;
  localparam int SIZE_MAX   = 40;
  localparam int SIZE_COUNT = SIZE_MAX - SIZE_MIN + 1;
  localparam int SIZE_IDX_W = $clog2(SIZE_COUNT);

  // Register widths and reset values.
  localparam int ORIGIN_W = 10;
  localparam int CELL_W   = 4;
  localparam int BORDER_REG_W = 12;
  localparam int BW_FRAC  = 12;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CELL_W-1:0]       CELL_WIDTH_RESET   = 4'd2;
  localparam logic [CELL_W-1:0]       CELL_HEIGHT_RESET  = 4'd4;
  localparam logic [SIZE_W-1:0]       TRI_SIZE_RESET     = 6'd14;
  localparam logic [BORDER_REG_W-1:0] BORDER_WIDTH_RESET = 12'd410;

  // Result fields.
  localparam int ADDR_W   = 12;
  localparam int ADDR_MAX = 2 ** (ADDR_W - 1) - 1;
  localparam int ADDR_MIN = -(2 ** (ADDR_W - 1));
  localparam int GLYPH_W  = 2;
  localparam int OUT_FIELDS_W = 2 * ADDR_W + 1 + GLYPH_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ORIGIN_COL   = 3'd0,
    CFG_ORIGIN_ROW   = 3'd1,
    CFG_CELL_WIDTH   = 3'd2,
    CFG_CELL_HEIGHT  = 3'd3,
    CFG_TRI_SIZE     = 3'd4,
    CFG_BORDER_WIDTH = 3'd5
  } cfg_idx_t;

  typedef enum logic [GLYPH_W-1:0] {
    GLYPH_SLASH      = 2'd0,
    GLYPH_BACKSLASH  = 2'd1,
    GLYPH_UNDERSCORE = 2'd2
  } glyph_t;

  typedef struct packed {
    logic [RECIP_W-1:0] inv_size;
    logic [RECIP_W-1:0] inv_h;
  } recip_t;

endpackage

/* rtl/tgr_recip.sv */
module tgr_recip
  import tgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [SIZE_W-1:0] size,
  output recip_t            recip
);

  logic [RECIP_W-1:0]    inv_size_tab [SIZE_COUNT];
  logic [RECIP_W-1:0]    inv_h_tab    [SIZE_COUNT];
  logic [SIZE_W-1:0]     size_sel;
  logic [SIZE_W-1:0]     size_sat;
  logic [SIZE_IDX_W-1:0] idx;

  // One entry per legal triangle size, worked out at elaboration.
  for (genvar g = 0; g < SIZE_COUNT; g++) begin : g_tab
    localparam longint unsigned S     = longint'(SIZE_MIN + g);
    localparam longint unsigned INV_S = ((64'd1 << RECIP_BITS) + S / 2) / S;
    localparam longint unsigned INV_H = (INV_H_NUM + S / 2) / S;
    assign inv_size_tab[g] = RECIP_W'(INV_S);
    assign inv_h_tab[g]    = RECIP_W'(INV_H);
  end

  always_comb begin
    size_sel = rst ? TRI_SIZE_RESET : size;
    if (size_sel < SIZE_W'(SIZE_MIN)) begin
      size_sat = SIZE_W'(SIZE_MIN);
    end else if (size_sel > SIZE_W'(SIZE_MAX)) begin
      size_sat = SIZE_W'(SIZE_MAX);
    end else begin
      size_sat = size_sel;
    end
    idx = SIZE_IDX_W'(size_sat - SIZE_W'(SIZE_MIN));
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      recip.inv_size <= inv_size_tab[idx];
      recip.inv_h    <= inv_h_tab[idx];
    end
  end

endmodule

/* rtl/triangle_grid_edge_raster_top.sv */
// Channel   Direction  Word fields (lowest bit first)
// s_axis    in         screen_col, screen_row
// m_axis    out        tri_col, tri_row, up_flag, glyph_code, on_edge
// cfg       in         write-only register port, index 0..5
//
// One word enters per cycle unless a stall on m_axis holds the pipeline.
// Its register stages hold the pixel offsets, the two reciprocal products,
// the rounded skewed coordinates, the floor and classification, and the edge minimum.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// A stall on m_axis freezes every stage at once, so nothing is lost or repeated.
module triangle_grid_edge_raster_top
  import tgr_pkg::*;
#(
  parameter int FRAC_BITS   = 12,
  parameter int SCREEN_BITS = 10,
  localparam int IN_TDATA_W = ((2 * SCREEN_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input word: screen_col, screen_row, zero padding.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Output word: tri_col, tri_row, up_flag, glyph_code, on_edge, zero padding.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Pixel offsets, products and the skewed coordinates after rounding.
  localparam int DIFF_W = SCREEN_BITS + 1;
  localparam int PW     = SCREEN_BITS + CELL_W + 2;
  localparam int PROD_W = PW + RECIP_W + 1;
  localparam int AW     = PROD_W + 2;
  localparam int BW     = PROD_W + 1;
  localparam int A_SHIFT = RECIP_BITS + 1 - FRAC_BITS;
  localparam int B_SHIFT = RECIP_BITS - FRAC_BITS;
  localparam logic signed [AW-1:0] ROUND_A = AW'(1) <<< (RECIP_BITS - FRAC_BITS);
  localparam logic signed [BW-1:0] ROUND_B = BW'(1) <<< (RECIP_BITS - FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int DIST_W = FRAC_BITS + 1;
  localparam int CMP_W  = FRAC_BITS + 1 + BW_FRAC;

  // ---------------- configuration registers ----------------
  logic [ORIGIN_W-1:0]     origin_col;
  logic [ORIGIN_W-1:0]     origin_row;
  logic [CELL_W-1:0]       cell_width;
  logic [CELL_W-1:0]       cell_height;
  logic [BORDER_REG_W-1:0] border_width;
  logic                    size_load;
  recip_t                  recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_col   <= '0;
      origin_row   <= '0;
      cell_width   <= CELL_WIDTH_RESET;
      cell_height  <= CELL_HEIGHT_RESET;
      border_width <= BORDER_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_COL:   origin_col   <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_ROW:   origin_row   <= cfg_data[ORIGIN_W-1:0];
        CFG_CELL_WIDTH:   cell_width   <= cfg_data[CELL_W-1:0];
        CFG_CELL_HEIGHT:  cell_height  <= cfg_data[CELL_W-1:0];
        CFG_BORDER_WIDTH: border_width <= cfg_data[BORDER_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // The reciprocals are looked up at reset and when the size register is written.
  assign size_load = cfg_we && (cfg_idx_t'(cfg_index) == CFG_TRI_SIZE);

  tgr_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .load  (size_load),
    .size  (cfg_data[SIZE_W-1:0]),
    .recip (recip)
  );

  // ---------------- pipeline control ----------------
  // All stages move together; the whole pipe holds while the output word waits.
  logic       adv;
  logic [3:0] v;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v             <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v             <= {v[2:0], s_axis_tvalid};
      m_axis_tvalid <= v[3];
    end
  end

  // ---------------- stage 1: pixel offsets ----------------
  logic [SCREEN_BITS-1:0]   scr_col;
  logic [SCREEN_BITS-1:0]   scr_row;
  logic signed [DIFF_W-1:0] dcol;
  logic signed [DIFF_W-1:0] drow;
  logic signed [PW-1:0]     px1;
  logic signed [PW-1:0]     py1;

  assign scr_col = s_axis_tdata[SCREEN_BITS-1:0];
  assign scr_row = s_axis_tdata[2*SCREEN_BITS-1:SCREEN_BITS];
  assign dcol = $signed({1'b0, scr_col}) - $signed({1'b0, SCREEN_BITS'(origin_col)});
  assign drow = $signed({1'b0, scr_row}) - $signed({1'b0, SCREEN_BITS'(origin_row)});

  always_ff @(posedge clk) begin
    if (adv) begin
      px1 <= PW'(dcol) * PW'($signed({1'b0, cell_width}));
      py1 <= PW'(drow) * PW'($signed({1'b0, cell_height}));
    end
  end

  // ---------------- stage 2: reciprocal products ----------------
  logic signed [PROD_W-1:0] pa2;
  logic signed [PROD_W-1:0] pb2;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa2 <= PROD_W'(px1) * PROD_W'($signed({1'b0, recip.inv_size}));
      pb2 <= PROD_W'(py1) * PROD_W'($signed({1'b0, recip.inv_h}));
    end
  end

  // ---------------- stage 3: skewed coordinates ----------------
  // a = px/size - b/2 and b = py/h, rounded to FRAC_BITS fraction bits.
  // Arithmetic right shifts give the floor for negative values too.
  logic signed [AW-1:0] aw;
  logic signed [AW-1:0] a3;
  logic signed [BW-1:0] b3;

  assign aw = (AW'(pa2) <<< 1) - AW'(pb2);

  always_ff @(posedge clk) begin
    if (adv) begin
      a3 <= (aw + ROUND_A) >>> A_SHIFT;
      b3 <= (BW'(pb2) + ROUND_B) >>> B_SHIFT;
    end
  end

  // ---------------- stage 4: cell address and edge distances ----------------
  logic signed [AW-1:0]     col_w;
  logic signed [BW-1:0]     row_w;
  logic [FRAC_BITS-1:0]     fa;
  logic [FRAC_BITS-1:0]     fb;
  logic [FRAC_BITS:0]       fsum;
  logic                     up_c;
  logic [DIST_W-1:0]        d1_c, d2_c, d3_c;
  logic signed [ADDR_W-1:0] col_c;
  logic signed [ADDR_W-1:0] row_c;

  logic signed [ADDR_W-1:0] col4;
  logic signed [ADDR_W-1:0] row4;
  logic                     up4;
  logic [DIST_W-1:0]        d1_4, d2_4, d3_4;

  always_comb begin
    col_w = a3 >>> FRAC_BITS;
    row_w = b3 >>> FRAC_BITS;
    fa    = a3[FRAC_BITS-1:0];
    fb    = b3[FRAC_BITS-1:0];
    fsum  = {1'b0, fa} + {1'b0, fb};
    up_c  = fsum >= ONE;

    if (col_w > AW'(ADDR_MAX)) begin
      col_c = ADDR_W'(ADDR_MAX);
    end else if (col_w < AW'(ADDR_MIN)) begin
      col_c = ADDR_W'(ADDR_MIN);
    end else begin
      col_c = ADDR_W'(col_w);
    end
    if (row_w > BW'(ADDR_MAX)) begin
      row_c = ADDR_W'(ADDR_MAX);
    end else if (row_w < BW'(ADDR_MIN)) begin
      row_c = ADDR_W'(ADDR_MIN);
    end else begin
      row_c = ADDR_W'(row_w);
    end

    // Candidate order matters: on a tie the earlier edge wins.
    if (!up_c) begin
      d1_c = ONE - fsum;
      d2_c = {1'b0, fa};
      d3_c = {1'b0, fb};
    end else begin
      d1_c = ONE - {1'b0, fb};
      d2_c = fsum - ONE;
      d3_c = ONE - {1'b0, fa};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col4 <= col_c;
      row4 <= row_c;
      up4  <= up_c;
      d1_4 <= d1_c;
      d2_4 <= d2_c;
      d3_4 <= d3_c;
    end
  end

  // ---------------- stage 5: nearest edge and border test ----------------
  glyph_t                   g1, g2, g3, glyph_c, glyph_out;
  logic [DIST_W-1:0]        dmin;
  logic [CMP_W-1:0]         dist_cmp;
  logic [CMP_W-1:0]         border_cmp;
  logic signed [ADDR_W-1:0] col_out;
  logic signed [ADDR_W-1:0] row_out;
  logic                     up_out;
  logic                     edge_out;

  always_comb begin
    g1 = up4 ? GLYPH_UNDERSCORE : GLYPH_SLASH;
    g2 = up4 ? GLYPH_SLASH      : GLYPH_BACKSLASH;
    g3 = up4 ? GLYPH_BACKSLASH  : GLYPH_UNDERSCORE;
    dmin    = d1_4;
    glyph_c = g1;
    if (d2_4 < dmin) begin
      dmin    = d2_4;
      glyph_c = g2;
    end
    if (d3_4 < dmin) begin
      dmin    = d3_4;
      glyph_c = g3;
    end
    // Align both sides to FRAC_BITS + BW_FRAC fraction bits for an exact compare.
    dist_cmp   = {dmin, {BW_FRAC{1'b0}}};
    border_cmp = {1'b0, border_width, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_out   <= col4;
      row_out   <= row4;
      up_out    <= up4;
      glyph_out <= glyph_c;
      edge_out  <= dist_cmp < border_cmp;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                         edge_out, glyph_out, up_out, row_out, col_out};

  // ---------------- assertions ----------------
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v[0])
    else $error("accepted word did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v) && $stable(col4) && $stable(d1_4))
    else $error("pipeline moved during a stall");

  a_last_stage_out: assert property (@(posedge clk) disable iff (rst)
    adv && v[3] |=> m_axis_tvalid)
    else $error("word from the last stage did not reach the output");

  a_glyph_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (glyph_out == GLYPH_SLASH || glyph_out == GLYPH_BACKSLASH ||
                       glyph_out == GLYPH_UNDERSCORE))
    else $error("unknown glyph code on output");

endmodule

/* dv/tb_triangle_grid_edge_raster_top.sv */
`timescale 1ns / 100ps

module tb_triangle_grid_edge_raster_top;
  import tgr_pkg::*;

  localparam int FRAC_BITS    = 12;
  localparam int SCREEN_BITS  = 10;
  localparam int IN_TDATA_W   = ((2 * SCREEN_BITS + 7) / 8) * 8;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 175;
  // Long enough that the five-stage pipeline fills and s_axis_tready drops.
  localparam int LONG_HOLD    = 200;
  // The pipeline is five stages deep; this leaves some margin on top.
  localparam int DRAIN_CYCLES = 12;
  localparam longint TIMEOUT_NS = 6_000_000;

  // Register indexes the block does not decode; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

  // Input word layout: screen_col in the low bits, screen_row above it.
  typedef struct packed {
    logic [SCREEN_BITS-1:0] row;
    logic [SCREEN_BITS-1:0] col;
  } screen_cell_t;

  // Output word layout, lowest field last in the list.
  typedef struct packed {
    logic                      on_edge;
    glyph_t                    glyph;
    logic                      up;
    logic signed [ADDR_W-1:0]  row;
    logic signed [ADDR_W-1:0]  col;
  } tri_cell_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  triangle_grid_edge_raster_top #(
    .FRAC_BITS   (FRAC_BITS),
    .SCREEN_BITS (SCREEN_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the register file. It is only updated while the block
  // is idle, so it always matches what the block used for words in flight.
  logic [ORIGIN_W-1:0]     grid_origin_col = '0;
  logic [ORIGIN_W-1:0]     grid_origin_row = '0;
  logic [CELL_W-1:0]       grid_cell_width = CELL_WIDTH_RESET;
  logic [CELL_W-1:0]       grid_cell_height = CELL_HEIGHT_RESET;
  logic [SIZE_W-1:0]       grid_tri_size = TRI_SIZE_RESET;
  logic [BORDER_REG_W-1:0] grid_border = BORDER_WIDTH_RESET;

  screen_cell_t cells_to_send[$];
  tri_cell_t    expected_cells[$];

  bit        idle_on = 1'b1;      // random gaps on both sides when set
  bit        s_fire = 1'b0;       // input word taken at the last rising edge
  int        send_gap = 0;
  int        ready_gap = 0;
  int        holds_asked = 0;     // bumped by the sequencer to request a long hold
  int        holds_done = 0;
  int        fail_count = 0;
  tri_cell_t want_cell;
  tri_cell_t got_cell;

  // Maps one screen cell to its triangle address, nearest edge and border flag
  // with the current register settings. Everything is done in 64-bit signed
  // arithmetic; an arithmetic right shift of a signed value is a floor.
  function automatic tri_cell_t classify_cell(screen_cell_t scr);
    longint    one;
    longint    tri_len;
    longint    inv_size;
    longint    inv_h;
    longint    px;
    longint    py;
    longint    bw;
    longint    aw;
    longint    a;
    longint    b;
    longint    col;
    longint    row;
    longint    fa;
    longint    fb;
    longint    m;
    longint    reach[3];
    glyph_t    edge_code[3];
    glyph_t    g;
    tri_cell_t res;
    one = longint'(1) << FRAC_BITS;
    // Out-of-range sizes are clamped before the reciprocals are formed.
    tri_len = longint'(grid_tri_size);
    if (tri_len < SIZE_MIN) tri_len = SIZE_MIN;
    if (tri_len > SIZE_MAX) tri_len = SIZE_MAX;
    inv_size = ((longint'(1) << RECIP_BITS) + tri_len / 2) / tri_len;
    inv_h    = (longint'(INV_H_NUM) + tri_len / 2) / tri_len;
    // Pixel offsets are signed; a zero cell size collapses that axis.
    px = (longint'(scr.col) - longint'(grid_origin_col)) * longint'(grid_cell_width);
    py = (longint'(scr.row) - longint'(grid_origin_row)) * longint'(grid_cell_height);
    bw = py * inv_h;
    aw = 2 * px * inv_size - bw;
    b = (bw + (longint'(1) << (RECIP_BITS - FRAC_BITS - 1))) >>> (RECIP_BITS - FRAC_BITS);
    a = (aw + (longint'(1) << (RECIP_BITS - FRAC_BITS))) >>> (RECIP_BITS + 1 - FRAC_BITS);
    col = a >>> FRAC_BITS;
    row = b >>> FRAC_BITS;
    fa = a & (one - 1);
    fb = b & (one - 1);
    res.up = (fa + fb >= one);
    // Candidate edges in priority order; a tie keeps the earlier one.
    if (!res.up) begin
      reach[0] = one - fa - fb;  edge_code[0] = GLYPH_SLASH;
      reach[1] = fa;             edge_code[1] = GLYPH_BACKSLASH;
      reach[2] = fb;             edge_code[2] = GLYPH_UNDERSCORE;
    end else begin
      reach[0] = one - fb;       edge_code[0] = GLYPH_UNDERSCORE;
      reach[1] = fa + fb - one;  edge_code[1] = GLYPH_SLASH;
      reach[2] = one - fa;       edge_code[2] = GLYPH_BACKSLASH;
    end
    m = reach[0];
    g = edge_code[0];
    for (int i = 1; i < 3; i++) begin
      if (reach[i] < m) begin
        m = reach[i];
        g = edge_code[i];
      end
    end
    res.glyph   = g;
    res.on_edge = (m << BW_FRAC) < (longint'(grid_border) << FRAC_BITS);
    // The address saturates, the fractions used above do not.
    res.col = ADDR_W'((col > ADDR_MAX) ? ADDR_MAX : ((col < ADDR_MIN) ? ADDR_MIN : col));
    res.row = ADDR_W'((row > ADDR_MAX) ? ADDR_MAX : ((row < ADDR_MIN) ? ADDR_MIN : row));
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Most cells land near the origin, where the grid address stays in range
  // for any setting; the rest cover the whole screen to reach saturation.
  function automatic screen_cell_t pick_cell();
    screen_cell_t c;
    if ($urandom_range(0, 9) < 6) begin
      c.col = SCREEN_BITS'(int'(grid_origin_col) + int'($urandom_range(0, 127)) - 64);
      c.row = SCREEN_BITS'(int'(grid_origin_row) + int'($urandom_range(0, 127)) - 64);
    end else begin
      c = screen_cell_t'((2 * SCREEN_BITS)'($urandom));
    end
    return c;
  endfunction

  // Input driver: a new word is offered at the falling edge once the previous
  // one was taken, optionally after a random gap.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cells_to_send.size() > 0) begin
        s_axis_tdata  <= {{(IN_TDATA_W - 2 * SCREEN_BITS){1'b0}}, cells_to_send.pop_front()};
        s_axis_tvalid <= 1'b1;
        send_gap = pick_gap(idle_on);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, plus a long hold whenever the sequencer asks
  // for one. The hold length is counted here, independent of the sender.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_gap = 0;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      ready_gap = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      ready_gap = pick_gap(idle_on);
    end
  end

  // Monitor: every accepted input word gets its expected result queued, and
  // every accepted output word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      s_fire = 1'b0;
    end else begin
      s_fire = s_axis_tvalid && s_axis_tready;
      if (s_fire) begin
        expected_cells.push_back(classify_cell(screen_cell_t'(s_axis_tdata[2*SCREEN_BITS-1:0])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_cell = tri_cell_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
        if (expected_cells.size() == 0) begin
          $error("result word %h arrived with nothing expected", m_axis_tdata);
          fail_count++;
        end else begin
          want_cell = expected_cells.pop_front();
          if (got_cell.col !== want_cell.col) begin
            $error("tri_col: expected %0d, got %0d", want_cell.col, got_cell.col);
            fail_count++;
          end
          if (got_cell.row !== want_cell.row) begin
            $error("tri_row: expected %0d, got %0d", want_cell.row, got_cell.row);
            fail_count++;
          end
          if (got_cell.up !== want_cell.up) begin
            $error("up_flag: expected %0d, got %0d", want_cell.up, got_cell.up);
            fail_count++;
          end
          if (got_cell.glyph !== want_cell.glyph) begin
            $error("glyph_code: expected %0d, got %0d", want_cell.glyph, got_cell.glyph);
            fail_count++;
          end
          if (got_cell.on_edge !== want_cell.on_edge) begin
            $error("on_edge: expected %0d, got %0d", want_cell.on_edge, got_cell.on_edge);
            fail_count++;
          end
        end
      end
    end
  end

  // Register write through the config port, mirrored into our own copy.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ORIGIN_COL:   grid_origin_col  = val[ORIGIN_W-1:0];
      CFG_ORIGIN_ROW:   grid_origin_row  = val[ORIGIN_W-1:0];
      CFG_CELL_WIDTH:   grid_cell_width  = val[CELL_W-1:0];
      CFG_CELL_HEIGHT:  grid_cell_height = val[CELL_W-1:0];
      CFG_TRI_SIZE:     grid_tri_size    = val[SIZE_W-1:0];
      CFG_BORDER_WIDTH: grid_border      = val[BORDER_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(int oc, int orow, int cw, int ch, int ts, int bwid);
    write_reg(CFG_ORIGIN_COL, CFG_DATA_W'(oc));
    write_reg(CFG_ORIGIN_ROW, CFG_DATA_W'(orow));
    write_reg(CFG_CELL_WIDTH, CFG_DATA_W'(cw));
    write_reg(CFG_CELL_HEIGHT, CFG_DATA_W'(ch));
    write_reg(CFG_TRI_SIZE, CFG_DATA_W'(ts));
    write_reg(CFG_BORDER_WIDTH, CFG_DATA_W'(bwid));
  endtask

  task automatic push_cell(int c, int r);
    screen_cell_t scr;
    scr.col = SCREEN_BITS'(c);
    scr.row = SCREEN_BITS'(r);
    cells_to_send.push_back(scr);
  endtask

  // Waits until every queued word went in and every result came back, then
  // lets the pipeline settle before the registers may change again.
  task automatic drain();
    while (cells_to_send.size() != 0 || s_axis_tvalid || expected_cells.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int oc;
    int orow;
    int cw;
    int ch;
    int ts;
    int bwid;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults. A cell on the origin sits exactly on a lattice point,
    // where the backslash and underscore distances tie at zero and the earlier edge must win.
    push_cell(0, 0);
    push_cell(1023, 1023);
    push_cell(0, 1023);
    push_cell(1023, 0);
    push_cell(1, 0);
    push_cell(0, 1);
    push_cell(7, 3);
    push_cell(3, 7);
    push_cell(512, 512);
    push_cell(341, 682);
    drain();

    // Largest cells, size below range (clamped up), widest border: the grid
    // address saturates at its low end and almost everything is on an edge.
    set_grid(1023, 1023, 15, 15, 0, 4095);
    write_reg(CFG_SPARE_6, 12'hFFF);
    write_reg(CFG_SPARE_7, 12'h000);
    push_cell(0, 0);
    push_cell(1023, 1023);
    push_cell(0, 1023);
    push_cell(1023, 0);
    drain();

    // Zero cell width, size above range (clamped down), no border at all.
    set_grid(0, 0, 0, 8, 63, 0);
    push_cell(1023, 1023);
    push_cell(5, 9);
    push_cell(0, 0);
    drain();

    // Zero cell height with an off-center origin.
    set_grid(200, 300, 8, 0, 40, 2048);
    push_cell(1023, 0);
    push_cell(150, 300);
    push_cell(201, 301);
    drain();

    // Random phases: the first two use the ends of the documented ranges, the
    // rest random settings that now and then leave those ranges.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        set_grid(0, 0, 1, 1, SIZE_MIN, 0);
      end else if (p == 1) begin
        set_grid(1023, 1023, 8, 8, SIZE_MAX, 4095);
      end else begin
        oc   = $urandom_range(0, 1023);
        orow = $urandom_range(0, 1023);
        cw   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        ch   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        ts   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                           : $urandom_range(SIZE_MIN, SIZE_MAX);
        bwid = $urandom_range(0, 4095);
        set_grid(oc, orow, cw, ch, ts, bwid);
      end
      // Every fourth phase runs with no gaps at all on either side.
      idle_on = (p % 4 != 2);
      // Two phases start with a long receiver hold while words keep coming.
      if (p == 3 || p == 7) holds_asked++;
      for (int i = 0; i < PHASE_ITEMS; i++) cells_to_send.push_back(pick_cell());
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

/* triangle_grid_edge_raster_top.f */
rtl/tgr_pkg.sv
rtl/tgr_recip.sv
rtl/triangle_grid_edge_raster_top.sv
dv/tb_triangle_grid_edge_raster_top.sv
